// ===== hw/rtl/bmhq_pkg.sv =====
package bmhq_pkg;

   localparam int unsigned CAPACITY_DEF = 256;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned COUNT_W      = 9;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned REQ_DATA_W   = 32;
   localparam int unsigned RSP_DATA_W   = 80;

   localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_REMOVE_EMPTY = 2'd1,
      ST_INSERT_FULL  = 2'd2
   } status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Datapath commands issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      DP_NONE,
      DP_INS_START,
      DP_REM_START,
      DP_REJ_FULL,
      DP_REJ_EMPTY,
      DP_UP_CHECK,
      DP_UP_CMP,
      DP_DN_LAST,
      DP_DN_LOAD,
      DP_DN_CHILD,
      DP_DN_RIGHT,
      DP_DN_CMP,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic up_swap;
      logic has_left;
      logic dn_stop;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/binary_max_heap_queue_top.sv =====
// Channel   Dir  Handshake            Contents
// req       in   req_tvalid/tready    tdata: value; tuser: operation
// rsp       out  rsp_tvalid/tready    tdata: removed, max, count, empty; tuser: status
//
// One item is in work at a time. An insert climbs the heap a level at a time and
// stops at the root or below it; a remove sifts down a level at a time and stops at
// a leaf or above it. The steps are paced by the single heap memory read port, whose
// read data is registered. Reset clears the count and the pending result, not the
// memory. A waiting result only holds back the next.
module binary_max_heap_queue_top #(
   parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] value
   input  logic [bmhq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] removed_value, [63:32] current_max, [72:64] entry_count,
   // [73] is_empty, [79:74] zero
   output logic [bmhq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [bmhq_pkg::STATUS_W-1:0]      rsp_tuser
);

   bmhq_pkg::dp_op_type     dp_op;
   bmhq_pkg::dp_status_type dp_status;

   logic signed [bmhq_pkg::DATA_W-1:0] rsp_removed;
   logic signed [bmhq_pkg::DATA_W-1:0] rsp_max;
   logic [bmhq_pkg::COUNT_W-1:0]       rsp_count;
   logic                               rsp_empty;
   bmhq_pkg::status_type               rsp_status;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .dp_status (dp_status),
      .dp_op     (dp_op)
   );

   bmhq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .dp_op       (dp_op),
      .dp_status   (dp_status),
      .in_value    (req_tdata[bmhq_pkg::DATA_W-1:0]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_removed (rsp_removed),
      .rsp_max     (rsp_max),
      .rsp_count   (rsp_count),
      .rsp_empty   (rsp_empty),
      .rsp_status  (rsp_status)
   );

   assign rsp_tdata = {6'b0, rsp_empty, rsp_count, rsp_max, rsp_removed};
   assign rsp_tuser = rsp_status;

endmodule

// ===== hw/rtl/bmhq_dp.sv =====
module bmhq_dp #(
   parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bmhq_pkg::dp_op_type                  dp_op,
   output bmhq_pkg::dp_status_type              dp_status,
   input  logic signed [bmhq_pkg::DATA_W-1:0]   in_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bmhq_pkg::DATA_W-1:0]   rsp_removed,
   output logic signed [bmhq_pkg::DATA_W-1:0]   rsp_max,
   output logic [bmhq_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                 rsp_empty,
   output bmhq_pkg::status_type                 rsp_status
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = AW + 2;

   logic signed [bmhq_pkg::DATA_W-1:0] mem [CAPACITY];
   logic signed [bmhq_pkg::DATA_W-1:0] rd_data_ff;

   logic [CW-1:0] count_ff,  count_in;
   logic [AW-1:0] pos_ff,    pos_in;
   logic signed [bmhq_pkg::DATA_W-1:0] val_ff, val_in;
   logic signed [bmhq_pkg::DATA_W-1:0] left_ff, left_in;
   logic signed [bmhq_pkg::DATA_W-1:0] root_ff, root_in;
   logic signed [bmhq_pkg::DATA_W-1:0] removed_ff, removed_in;
   bmhq_pkg::status_type status_ff, status_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [bmhq_pkg::DATA_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic signed [bmhq_pkg::DATA_W-1:0] rsp_max_ff, rsp_max_in;
   logic [bmhq_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic rsp_empty_ff, rsp_empty_in;
   bmhq_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic signed [bmhq_pkg::DATA_W-1:0] wr_data;

   logic [PW-1:0] left_idx, right_idx, count_ext;
   logic [AW-1:0] parent_idx;
   logic          left_wins, right_ok, take_right;
   logic signed [bmhq_pkg::DATA_W-1:0] best_val;

   assign count_ext  = PW'(count_ff);
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + PW'(1);
   assign parent_idx = (pos_ff - AW'(1)) >> 1;

   // Down step: the right child wins only over the larger of parent and left.
   assign left_wins  = val_ff < left_ff;
   assign best_val   = left_wins ? left_ff : val_ff;
   assign right_ok   = right_idx < count_ext;
   assign take_right = right_ok && (rd_data_ff > best_val);

   always_comb begin
      dp_status.full     = count_ff == CW'(CAPACITY);
      dp_status.empty    = count_ff == '0;
      dp_status.at_root  = pos_ff == '0;
      dp_status.up_swap  = val_ff > rd_data_ff;
      dp_status.has_left = left_idx < count_ext;
      dp_status.dn_stop  = !left_wins && !take_right;
      dp_status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      rd_addr = parent_idx;
      case (dp_op)
         bmhq_pkg::DP_DN_LAST:  rd_addr = count_ff[AW-1:0];
         bmhq_pkg::DP_DN_CHILD: rd_addr = left_idx[AW-1:0];
         bmhq_pkg::DP_DN_RIGHT: rd_addr = right_idx[AW-1:0];
         default:               rd_addr = parent_idx;
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      left_in        = left_ff;
      removed_in     = removed_ff;
      status_in      = status_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = val_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_removed_in = rsp_removed_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_status_in  = rsp_status_ff;
      case (dp_op)
         bmhq_pkg::DP_INS_START: begin
            count_in   = count_ff + CW'(1);
            pos_in     = count_ff[AW-1:0];
            val_in     = in_value;
            removed_in = '0;
            status_in  = bmhq_pkg::ST_OK;
         end
         bmhq_pkg::DP_REM_START: begin
            count_in   = count_ff - CW'(1);
            removed_in = root_ff;
            status_in  = bmhq_pkg::ST_OK;
         end
         bmhq_pkg::DP_REJ_FULL: begin
            removed_in = '0;
            status_in  = bmhq_pkg::ST_INSERT_FULL;
         end
         bmhq_pkg::DP_REJ_EMPTY: begin
            removed_in = '0;
            status_in  = bmhq_pkg::ST_REMOVE_EMPTY;
         end
         bmhq_pkg::DP_UP_CHECK: begin
            wr_en = pos_ff == '0;
         end
         bmhq_pkg::DP_UP_CMP: begin
            // The moving value stays in a register; the smaller parent drops
            // into the hole instead of a full swap.
            wr_en = 1'b1;
            if (val_ff > rd_data_ff) begin
               wr_data = rd_data_ff;
               pos_in  = parent_idx;
            end
         end
         bmhq_pkg::DP_DN_LOAD: begin
            val_in = rd_data_ff;
            pos_in = '0;
         end
         bmhq_pkg::DP_DN_CHILD: begin
            wr_en = !(left_idx < count_ext);
         end
         bmhq_pkg::DP_DN_RIGHT: begin
            left_in = rd_data_ff;
         end
         bmhq_pkg::DP_DN_CMP: begin
            wr_en = 1'b1;
            if (take_right) begin
               wr_data = rd_data_ff;
               pos_in  = right_idx[AW-1:0];
            end else if (left_wins) begin
               wr_data = left_ff;
               pos_in  = left_idx[AW-1:0];
            end
         end
         bmhq_pkg::DP_PUBLISH: begin
            rsp_valid_in   = 1'b1;
            rsp_removed_in = removed_ff;
            rsp_max_in     = (count_ff == '0) ? bmhq_pkg::INT_MIN : root_ff;
            rsp_count_in   = bmhq_pkg::COUNT_W'(count_ff);
            rsp_empty_in   = count_ff == '0;
            rsp_status_in  = status_ff;
         end
         default: begin
         end
      endcase
   end

   // The root is mirrored in a register so the maximum needs no memory read.
   assign root_in = (wr_en && wr_addr == '0) ? wr_data : root_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      left_ff        <= left_in;
      root_ff        <= root_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_max_ff     <= rsp_max_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_max     = rsp_max_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_empty   = rsp_empty_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// ===== hw/rtl/bmhq_ctrl.sv =====
module bmhq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_op,
   output logic                     req_ready,
   input  bmhq_pkg::dp_status_type  dp_status,
   output bmhq_pkg::dp_op_type      dp_op
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_DN_LAST,
      S_DN_LOAD,
      S_DN_CHILD,
      S_DN_RIGHT,
      S_DN_CMP,
      S_PUBLISH
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      dp_op    = bmhq_pkg::DP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == bmhq_pkg::OP_INSERT) begin
                  if (dp_status.full) begin
                     dp_op    = bmhq_pkg::DP_REJ_FULL;
                     state_in = S_PUBLISH;
                  end else begin
                     dp_op    = bmhq_pkg::DP_INS_START;
                     state_in = S_UP_CHECK;
                  end
               end else begin
                  if (dp_status.empty) begin
                     dp_op    = bmhq_pkg::DP_REJ_EMPTY;
                     state_in = S_PUBLISH;
                  end else begin
                     dp_op    = bmhq_pkg::DP_REM_START;
                     state_in = S_DN_LAST;
                  end
               end
            end
         end
         S_UP_CHECK: begin
            dp_op    = bmhq_pkg::DP_UP_CHECK;
            state_in = dp_status.at_root ? S_PUBLISH : S_UP_CMP;
         end
         S_UP_CMP: begin
            dp_op    = bmhq_pkg::DP_UP_CMP;
            state_in = dp_status.up_swap ? S_UP_CHECK : S_PUBLISH;
         end
         S_DN_LAST: begin
            // Removing the only entry leaves nothing to sift.
            if (dp_status.empty) begin
               state_in = S_PUBLISH;
            end else begin
               dp_op    = bmhq_pkg::DP_DN_LAST;
               state_in = S_DN_LOAD;
            end
         end
         S_DN_LOAD: begin
            dp_op    = bmhq_pkg::DP_DN_LOAD;
            state_in = S_DN_CHILD;
         end
         S_DN_CHILD: begin
            dp_op    = bmhq_pkg::DP_DN_CHILD;
            state_in = dp_status.has_left ? S_DN_RIGHT : S_PUBLISH;
         end
         S_DN_RIGHT: begin
            dp_op    = bmhq_pkg::DP_DN_RIGHT;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            dp_op    = bmhq_pkg::DP_DN_CMP;
            state_in = dp_status.dn_stop ? S_PUBLISH : S_DN_CHILD;
         end
         S_PUBLISH: begin
            if (dp_status.rsp_free) begin
               dp_op    = bmhq_pkg::DP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
